// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the position seek controller.
// Needs a clock named i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: sv/dcmps_pkg.sv
// Shared types and constants of the DC motor position seek controller.
// No dependencies; used by every module of the block.
package dcmps_pkg;

    // Command bytes
    localparam logic [7:0] CODE_VERSION  = 8'd0;
    localparam logic [7:0] CODE_RUN_FWD  = 8'd1;
    localparam logic [7:0] CODE_RUN_REV  = 8'd2;
    localparam logic [7:0] CODE_LOAD_POS = 8'd3;
    localparam logic [7:0] CODE_READ_POS = 8'd4;
    localparam logic [7:0] CODE_GOTO     = 8'd5;
    localparam logic [7:0] CODE_COAST    = 8'd6;

    // Classified operations passed from the front to the back
    localparam logic [3:0] OP_OPTO    = 4'd0;
    localparam logic [3:0] OP_VERSION = 4'd1;
    localparam logic [3:0] OP_FORWARD = 4'd2;
    localparam logic [3:0] OP_REVERSE = 4'd3;
    localparam logic [3:0] OP_SETPOS  = 4'd4;
    localparam logic [3:0] OP_GETPOS  = 4'd5;
    localparam logic [3:0] OP_SEEK    = 4'd6;
    localparam logic [3:0] OP_FREE    = 4'd7;
    localparam logic [3:0] OP_NOP     = 4'd8;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_SEL = 2'd1;

    localparam logic [7:0] PWM_PERIOD_RESET = 8'd255;
    localparam logic [7:0] FULL_SPEED_DUTY  = 8'd255;
    localparam logic [7:0] VERSION_LO       = 8'd0;
    localparam logic [7:0] VERSION_HI       = 8'd1;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  speed;  // speed for drive commands and seek
        logic [15:0] word;   // new position or seek target
        logic        opto;
    } t_op;

endpackage

// File: sv/dc_motor_position_seek_controller.sv
// Top level of the DC motor position seek controller.
// Depends on dcmps_pkg, dcmps_front, dcmps_queue and dcmps_back.
//
// Input channel: one beat is either an opto sample (i_func = 0) or a
// command packet (i_func = 1), taken when i_in_valid is high and
// o_in_stall is low. Every input beat gives exactly one output beat,
// offered on o_out_valid and taken when i_out_stall is low.
// Configuration channel: i_cfg_index selects pwm_period (0) or
// prescale_sel (1); o_cfg_ready is always high and writes are meant to be
// made while the block is idle. Writing pwm_period clears full speed.
// An accepted input beat is written into the queue and then executed into
// the output register; throughput is one beat per cycle while the output
// is not stalled; the execute stage updates the position and drive state.
// When the receiver stalls, the output register holds its beat and the
// four-entry queue absorbs further input beats; o_in_stall rises only
// once the queue is full.
// Reset (i_rst_n low, synchronous) clears the position, target, seek and
// drive state, sets pwm_period to 255 and prescale_sel to 0, and empties
// the queue and output register. No clearing pass is needed.
module dc_motor_position_seek_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [7:0]                          i_cmd_code,
    input  logic [7:0]                          i_arg1,
    input  logic [7:0]                          i_arg2,
    input  logic [7:0]                          i_arg3,
    input  logic                                i_opto_level,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dcmps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_fwd_enable,
    output logic                                o_rev_enable,
    output logic [7:0]                          o_duty,
    output logic [7:0]                          o_period,
    output logic [1:0]                          o_prescale_out,
    output logic                                o_reply_valid,
    output logic [7:0]                          o_reply_lo,
    output logic [7:0]                          o_reply_hi,
    output logic                                o_seeking
);
    import dcmps_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_op  w_front_op;
    t_op  w_queue_op;

    assign o_in_stall  = w_full;
    assign o_cfg_ready = 1'b1;

    dcmps_front u_front (
        .i_in_valid   (i_in_valid),
        .i_full       (w_full),
        .i_func       (i_func),
        .i_cmd_code   (i_cmd_code),
        .i_arg1       (i_arg1),
        .i_arg2       (i_arg2),
        .i_arg3       (i_arg3),
        .i_opto_level (i_opto_level),
        .o_push       (w_push),
        .o_op         (w_front_op)
    );

    dcmps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_op    (w_queue_op)
    );

    dcmps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_op           (w_queue_op),
        .o_pop          (w_pop),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_fwd_enable   (o_fwd_enable),
        .o_rev_enable   (o_rev_enable),
        .o_duty         (o_duty),
        .o_period       (o_period),
        .o_prescale_out (o_prescale_out),
        .o_reply_valid  (o_reply_valid),
        .o_reply_lo     (o_reply_lo),
        .o_reply_hi     (o_reply_hi),
        .o_seeking      (o_seeking)
    );

endmodule

// File: sv/dcmps_front.sv
// Front end: accepts input beats and classifies them into operations.
// Depends on dcmps_pkg; feeds dcmps_queue.
module dcmps_front (
    input  logic             i_in_valid,
    input  logic             i_full,
    input  logic             i_func,
    input  logic [7:0]       i_cmd_code,
    input  logic [7:0]       i_arg1,
    input  logic [7:0]       i_arg2,
    input  logic [7:0]       i_arg3,
    input  logic             i_opto_level,
    output logic             o_push,
    output dcmps_pkg::t_op   o_op
);
    import dcmps_pkg::*;

    assign o_push = i_in_valid && !i_full;

    always_comb begin
        o_op.speed = i_arg1;
        o_op.opto  = i_opto_level;
        o_op.word  = {i_arg2, i_arg1};
        o_op.kind  = OP_NOP;
        if (!i_func) begin
            o_op.kind = OP_OPTO;
        end else begin
            unique case (i_cmd_code)
                CODE_VERSION:  o_op.kind = OP_VERSION;
                CODE_RUN_FWD:  o_op.kind = OP_FORWARD;
                CODE_RUN_REV:  o_op.kind = OP_REVERSE;
                CODE_LOAD_POS: o_op.kind = OP_SETPOS;
                CODE_READ_POS: o_op.kind = OP_GETPOS;
                CODE_GOTO: begin
                    o_op.kind = OP_SEEK;
                    o_op.word = {i_arg3, i_arg2};
                end
                CODE_COAST:    o_op.kind = OP_FREE;
                // Notify and unknown codes leave everything as it is.
                default:       o_op.kind = OP_NOP;
            endcase
        end
    end

endmodule

// File: sv/dcmps_queue.sv
// Short queue of classified operations between the front and the back.
// Depends on dcmps_pkg and assert_macros.svh.
module dcmps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dcmps_pkg::t_op i_op,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output dcmps_pkg::t_op o_op
);
    import dcmps_pkg::*;
    `include "assert_macros.svh"

    t_op                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

    `ASSERT_CLK(a_no_pop_empty, i_pop |-> !o_empty, "queue popped while empty")
    `ASSERT_CLK(a_no_push_full, o_full |-> !i_push, "queue pushed while full")
    `ASSERT_CLK(a_count_range, r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue count overflow")

endmodule

// File: sv/dcmps_back.sv
// Back end: carries out operations on the position and drive state and
// holds the result in an output register. Depends on dcmps_pkg and assert_macros.svh.
module dcmps_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  dcmps_pkg::t_op                      i_op,
    output logic                                o_pop,
    input  logic                                i_cfg_valid,
    input  logic [dcmps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_fwd_enable,
    output logic                                o_rev_enable,
    output logic [7:0]                          o_duty,
    output logic [7:0]                          o_period,
    output logic [1:0]                          o_prescale_out,
    output logic                                o_reply_valid,
    output logic [7:0]                          o_reply_lo,
    output logic [7:0]                          o_reply_hi,
    output logic                                o_seeking
);
    import dcmps_pkg::*;
    `include "assert_macros.svh"

    typedef struct packed {
        logic       fwd;
        logic       rev;
        logic [7:0] duty;
        logic       full;
        logic       dir;
    } t_drive;

    function automatic t_drive drive_calc(input logic [7:0] speed, input logic dir);
        t_drive d;
        d.fwd  = (speed != 8'd0) && !dir;
        d.rev  = (speed != 8'd0) && dir;
        d.duty = speed;
        d.full = (speed == FULL_SPEED_DUTY);
        d.dir  = dir;
        return d;
    endfunction

    // Configuration
    logic [7:0]  r_pwm_period;
    logic [1:0]  r_prescale;

    // Controller state
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_target, n_target;
    logic [7:0]  r_seek_speed, n_seek_speed;
    logic        r_dir, n_dir;
    logic        r_last_opto, n_last_opto;
    logic        r_fwd, n_fwd;
    logic        r_rev, n_rev;
    logic [7:0]  r_duty, n_duty;
    logic        r_full, n_full;

    // Output register
    logic        r_out_valid;
    logic        r_o_fwd, r_o_rev, r_o_reply_valid, r_o_seeking;
    logic [7:0]  r_o_duty, r_o_period, r_o_reply_lo, r_o_reply_hi;
    logic [1:0]  r_o_prescale;

    logic        n_reply_valid;
    logic [7:0]  n_reply_lo, n_reply_hi;
    logic [15:0] w_step_pos;
    t_drive      w_drv;

    assign o_pop = !i_empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_pos         = r_pos;
        n_target      = r_target;
        n_seek_speed  = r_seek_speed;
        n_dir         = r_dir;
        n_last_opto   = r_last_opto;
        n_fwd         = r_fwd;
        n_rev         = r_rev;
        n_duty        = r_duty;
        n_full        = r_full;
        n_reply_valid = 1'b0;
        n_reply_lo    = 8'd0;
        n_reply_hi    = 8'd0;
        w_step_pos    = r_dir ? (r_pos - 16'd1) : (r_pos + 16'd1);
        w_drv         = drive_calc(8'd0, 1'b0);

        unique case (i_op.kind) inside
            OP_OPTO: begin
                n_last_opto = i_op.opto;
                if (i_op.opto && !r_last_opto) begin
                    n_pos = w_step_pos;
                    // Arriving at the target ends the seek and cuts the drive.
                    if (r_seek_speed != 8'd0 && w_step_pos == r_target) begin
                        n_seek_speed = 8'd0;
                        n_fwd        = 1'b0;
                        n_rev        = 1'b0;
                        n_duty       = 8'd0;
                    end
                end
            end
            OP_VERSION: begin
                n_reply_valid = 1'b1;
                n_reply_lo    = VERSION_LO;
                n_reply_hi    = VERSION_HI;
            end
            OP_FORWARD, OP_REVERSE, OP_FREE: begin
                if (i_op.kind == OP_FREE) begin
                    w_drv = drive_calc(8'd0, 1'b0);
                end else begin
                    w_drv = drive_calc(i_op.speed, i_op.kind == OP_REVERSE);
                end
                {n_fwd, n_rev, n_duty, n_full, n_dir} = w_drv;
            end
            OP_SETPOS: n_pos = i_op.word;
            OP_GETPOS: begin
                n_reply_valid = 1'b1;
                n_reply_lo    = r_pos[7:0];
                n_reply_hi    = r_pos[15:8];
            end
            OP_SEEK: begin
                n_target = i_op.word;
                // A seek to where the motor already stands only stores the target.
                if (i_op.word != r_pos) begin
                    n_seek_speed = i_op.speed;
                    w_drv = drive_calc(i_op.speed, $signed(r_pos) > $signed(i_op.word));
                    {n_fwd, n_rev, n_duty, n_full, n_dir} = w_drv;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= PWM_PERIOD_RESET;
            r_prescale   <= 2'd0;
            r_pos        <= 16'd0;
            r_target     <= 16'd0;
            r_seek_speed <= 8'd0;
            r_dir        <= 1'b0;
            r_last_opto  <= 1'b0;
            r_fwd        <= 1'b0;
            r_rev        <= 1'b0;
            r_duty       <= 8'd0;
            r_full       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos        <= n_pos;
                r_target     <= n_target;
                r_seek_speed <= n_seek_speed;
                r_dir        <= n_dir;
                r_last_opto  <= n_last_opto;
                r_fwd        <= n_fwd;
                r_rev        <= n_rev;
                r_duty       <= n_duty;
                r_full       <= n_full;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_PWM_PERIOD: begin
                        r_pwm_period <= i_cfg_data;
                        r_full       <= 1'b0;
                    end
                    REG_PRESCALE_SEL: r_prescale <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_o_fwd         <= n_fwd;
            r_o_rev         <= n_rev;
            r_o_duty        <= n_duty;
            r_o_period      <= n_full ? 8'd0 : r_pwm_period;
            r_o_prescale    <= r_prescale;
            r_o_reply_valid <= n_reply_valid;
            r_o_reply_lo    <= n_reply_lo;
            r_o_reply_hi    <= n_reply_hi;
            r_o_seeking     <= (n_seek_speed != 8'd0);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fwd_enable   = r_o_fwd;
    assign o_rev_enable   = r_o_rev;
    assign o_duty         = r_o_duty;
    assign o_period       = r_o_period;
    assign o_prescale_out = r_o_prescale;
    assign o_reply_valid  = r_o_reply_valid;
    assign o_reply_lo     = r_o_reply_lo;
    assign o_reply_hi     = r_o_reply_hi;
    assign o_seeking      = r_o_seeking;

    `ASSERT_CLK(a_one_enable, !(r_fwd && r_rev), "both bridge enables set")
    `ASSERT_CLK(a_enable_duty, (r_fwd || r_rev) == (r_duty != 8'd0), "enable and duty disagree")
    `ASSERT_CLK(a_reply_zero, (r_out_valid && !r_o_reply_valid) |-> (r_o_reply_lo == 8'd0 && r_o_reply_hi == 8'd0), "reply bytes set without a reply")

endmodule
